// File: rtl/slm_pkg.sv
// Shared types and constants of the stereo log level meter.
// No dependencies; imported by every module of the block.
`default_nettype none

package slm_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int COUNT_BITS  = 17;
  localparam int DEN_BITS    = COUNT_BITS + CFG_BITS;

  // Log evaluation
  localparam int MANT_BITS   = 31;   // Q1.30 mantissa
  localparam int FRAC_BITS   = 20;   // log2 fraction bits
  localparam int LOG_C_BITS  = 31;
  localparam logic [LOG_C_BITS-1:0] LOG10_2_Q32 = 31'd1292913986;
  localparam int DIV_STEPS   = 30;
  localparam int SQR_STEPS   = 20;
  localparam int STEP_BITS   = 5;

  // Output rounding: channel keeps bits from 36, mono from 37
  localparam int CH_SHIFT    = 36;
  localparam int MONO_SHIFT  = 37;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  // Register map
  localparam logic [CFG_IDX_BITS-1:0] REG_UPDATE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_SCALE      = 2'd1;
  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 16'd2205;
  localparam logic [CFG_BITS-1:0] SCALE_RESET     = 16'd1000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          end_of_buffer;
  } slm_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_left;
    logic [LEVEL_BITS-1:0] level_right;
    logic [LEVEL_BITS-1:0] level_mono;
  } slm_out_t;

  // Controller to datapath
  typedef struct packed {
    logic acc_en;     // accumulate the transferred frame
    logic den_load;   // latch count * scale
    logic n_load;     // load numerator for the selected channel
    logic k_step;     // double the shifted denominator
    logic div_init;   // start the mantissa division
    logic div_step;   // one restoring division step
    logic sq_step;    // one squaring step of the log fraction
    logic p_store;    // scale log2 to log10 and store
    logic ch;         // 0 left, 1 right
    logic out_load;   // write the result register and clear state
  } slm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trigger;    // transferred frame starts an update
    logic k_more;     // denominator can still be doubled
  } slm_sts_t;

  // Magnitude of a two's complement sample
  function automatic logic [SAMPLE_BITS-1:0] abs_sample(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic [SAMPLE_BITS-1:0] u;
    u = s;
    return u[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/slm_datapath.sv
// Datapath of the level meter: accumulators, config registers, the shared
// log10 unit (normalize, divide, square) and the result register. Uses slm_pkg.
`default_nettype none

module slm_datapath import slm_pkg::*; #(
  parameter int SUM_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  slm_cmd_t                cmd,
  output slm_sts_t                sts,
  input  slm_in_t                 in_payload,
  input  wire                     cfg_we,
  input  wire [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [CFG_BITS-1:0]      cfg_data,
  output slm_out_t                out_payload
);

  localparam int NW = ((SUM_BITS > DEN_BITS) ? SUM_BITS : DEN_BITS) + 1;
  localparam int KW = $clog2(NW);
  localparam int LW = KW + FRAC_BITS;
  localparam int PW = LW + LOG_C_BITS;

  logic [CFG_BITS-1:0]   thr_r, scale_r;
  logic [SUM_BITS-1:0]   sum_left_r, sum_right_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [DEN_BITS-1:0]   den_r;
  logic [NW-1:0]         n_r, dk_r, r_r;
  logic [KW-1:0]         k_r;
  logic [MANT_BITS-1:0]  m_r;
  logic [FRAC_BITS-1:0]  frac_r;
  logic [PW-1:0]         pl_r, pr_r;
  slm_out_t              out_r;

  logic [COUNT_BITS-1:0] count_inc;
  logic [CFG_BITS-1:0]   scale_eff;
  logic [SUM_BITS-1:0]   sel_sum;
  logic [NW:0]           r_sh;
  logic                  div_ge;
  logic [2*MANT_BITS-1:0] sq;
  logic [MANT_BITS:0]    sq_hi;
  logic [LW-1:0]         l2;
  logic [PW-1:0]         p_new;
  logic [PW:0]           s_ch_l, s_ch_r;
  logic [PW+1:0]         s_mono;
  slm_out_t              lvl;

  function automatic logic [SUM_BITS-1:0] sat_add(
    input logic [SUM_BITS-1:0]    acc,
    input logic [SAMPLE_BITS-1:0] add
  );
    logic [SUM_BITS:0] t;
    t = {1'b0, acc} + (SUM_BITS+1)'(add);
    return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
  endfunction

  function automatic logic [LEVEL_BITS-1:0] ch_level(input logic [PW:0] s);
    return (|s[PW:CH_SHIFT+LEVEL_BITS]) ? LEVEL_MAX
                                        : s[CH_SHIFT+LEVEL_BITS-1:CH_SHIFT];
  endfunction

  // Update check and count
  assign count_inc   = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign sts.trigger = in_payload.end_of_buffer &&
                       ({count_inc, 1'b0} > {2'b00, thr_r});
  assign scale_eff   = (scale_r == '0) ? CFG_BITS'(1) : scale_r;
  assign sel_sum     = cmd.ch ? sum_right_r : sum_left_r;

  // Normalize: one doubling of the denominator per cycle
  assign sts.k_more = ({dk_r, 1'b0} <= {1'b0, n_r});

  // Restoring division step
  assign r_sh   = {r_r, 1'b0};
  assign div_ge = (r_sh >= {1'b0, dk_r});

  // Squaring step of the log2 fraction
  assign sq    = {{MANT_BITS{1'b0}}, m_r} * {{MANT_BITS{1'b0}}, m_r};
  assign sq_hi = sq[2*MANT_BITS-1:MANT_BITS-1];

  // log2 to log10
  assign l2    = {k_r, frac_r};
  assign p_new = PW'(l2) * PW'(LOG10_2_Q32);

  // Round and clamp the three levels
  assign s_ch_l = {1'b0, pl_r} + ((PW+1)'(1) << (CH_SHIFT - 1));
  assign s_ch_r = {1'b0, pr_r} + ((PW+1)'(1) << (CH_SHIFT - 1));
  assign s_mono = {2'b00, pl_r} + {2'b00, pr_r} + ((PW+2)'(1) << (MONO_SHIFT - 1));
  assign lvl.level_left  = ch_level(s_ch_l);
  assign lvl.level_right = ch_level(s_ch_r);
  assign lvl.level_mono  = (|s_mono[PW+1:MONO_SHIFT+LEVEL_BITS]) ? LEVEL_MAX
                         : s_mono[MONO_SHIFT+LEVEL_BITS-1:MONO_SHIFT];

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_UPDATE_THRESHOLD) thr_r <= cfg_data;
      if (cfg_index == REG_LEVEL_SCALE)      scale_r <= cfg_data;
    end
  end

  // Accumulators and frame count; clear after a result is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_left_r  <= '0;
      sum_right_r <= '0;
      count_r     <= '0;
    end else if (cmd.out_load) begin
      sum_left_r  <= '0;
      sum_right_r <= '0;
      count_r     <= '0;
    end else if (cmd.acc_en) begin
      sum_left_r  <= sat_add(sum_left_r, abs_sample(in_payload.sample_left));
      sum_right_r <= sat_add(sum_right_r, abs_sample(in_payload.sample_right));
      count_r     <= count_inc;
    end
  end

  // Log unit working registers
  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den_r <= DEN_BITS'(count_r) * DEN_BITS'(scale_eff);
    end
    if (cmd.n_load) begin
      n_r  <= NW'(sel_sum) + NW'(den_r);
      dk_r <= NW'(den_r);
      k_r  <= '0;
    end
    if (cmd.k_step) begin
      dk_r <= {dk_r[NW-2:0], 1'b0};
      k_r  <= k_r + 1'b1;
    end
    if (cmd.div_init) begin
      r_r    <= n_r - dk_r;
      m_r    <= MANT_BITS'(1);
      frac_r <= '0;
    end
    if (cmd.div_step) begin
      r_r <= div_ge ? NW'(r_sh - {1'b0, dk_r}) : r_sh[NW-1:0];
      m_r <= {m_r[MANT_BITS-2:0], div_ge};
    end
    if (cmd.sq_step) begin
      frac_r <= {frac_r[FRAC_BITS-2:0], sq_hi[MANT_BITS]};
      m_r    <= sq_hi[MANT_BITS] ? sq_hi[MANT_BITS:1] : sq_hi[MANT_BITS-1:0];
    end
    if (cmd.p_store) begin
      if (cmd.ch) pr_r <= p_new;
      else        pl_r <= p_new;
    end
    if (cmd.out_load) begin
      out_r <= lvl;
    end
  end

  assign out_payload = out_r;

endmodule

`default_nettype wire

// File: rtl/slm_ctrl.sv
// Controller of the level meter: sequences accumulate, normalize, divide,
// square and scale for both channels, and owns the handshakes. Uses slm_pkg.
`default_nettype none

module slm_ctrl import slm_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  input  slm_sts_t sts,
  output slm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEN   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_KSRCH = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SQR   = 3'd5;
  localparam logic [2:0] S_PMUL  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 ch_r, ch_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          ch_nxt     = 1'b0;
          if (sts.trigger) state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        cmd.n_load = 1'b1;
        state_nxt  = S_KSRCH;
      end
      S_KSRCH: begin
        if (sts.k_more) begin
          cmd.k_step = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_BITS'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_SQR;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SQR: begin
        cmd.sq_step = 1'b1;
        if (step_r == STEP_BITS'(SQR_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_PMUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_PMUL: begin
        cmd.p_store = 1'b1;
        if (ch_r) begin
          state_nxt = S_FIN;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_FIN: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stereo_log_level_meter.sv
// Top level of the stereo log level meter: joins slm_ctrl and slm_datapath.
// Uses slm_pkg for payload types and the register map.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | slm_in_t (one stereo frame)
//   out_    | output    | out_valid / out_ready| slm_out_t (three levels)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A frame that starts no update leaves the meter ready. An update runs, for
// each channel in turn, k normalize shifts (k at most SUM_BITS), the shared
// log unit's 30 division and 20 squaring steps and the log10 scaling, with
// in_ready low. A finished result waits in its output register while new
// frames are transferred; the next update waits for it before it is written.
// Reset is synchronous: accumulators and count clear, registers take defaults.
`default_nettype none

module stereo_log_level_meter import slm_pkg::*; #(
  parameter int SUM_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  slm_in_t                in_payload,
  output logic                   out_valid,
  input  wire                    out_ready,
  output slm_out_t               out_payload,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_IDX_BITS-1:0] cfg_index,
  input  wire [CFG_BITS-1:0]     cfg_data
);

  slm_cmd_t cmd;
  slm_sts_t sts;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slm_datapath #(
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_payload  (in_payload),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// File: rtl/slm_checker.sv
// Port-level checks of the stereo log level meter, bound to the top level.
// Uses slm_pkg for payload types.
`default_nettype none

module slm_checker import slm_pkg::*; (
  input wire      clk,
  input wire      rst_n,
  input wire      in_valid,
  input wire      in_ready,
  input slm_in_t  in_payload,
  input wire      out_valid,
  input wire      out_ready,
  input slm_out_t out_payload
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed or dropped while stalled");

  // Only an end-of-buffer frame can start a result
  a_no_eob_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_payload.end_of_buffer |=> !$rose(out_valid))
    else $error("result without an end-of-buffer frame");

  // A new result follows a cycle in which frames were held off
  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a compute phase");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stereo_log_level_meter slm_checker u_slm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);

`default_nettype wire

// File: verif/stereo_log_level_meter_tb.sv
// Self-checking testbench for stereo_log_level_meter: directed frames, then
// random stereo buffers across several threshold/scale settings.
// Depends on slm_pkg and the stereo_log_level_meter RTL only.

module stereo_log_level_meter_tb;
  import slm_pkg::*;

  localparam int STALL_LIMIT = 4000;  // quiet cycles before giving up
  localparam int SETTLE      = 200;   // covers one full update of both channels
  localparam int N_DIR       = 19;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_FRAME, ROW_CFG, ROW_CFG_STRAY} row_kind_t;

  // One step of the directed plan; lv/fires are used only when typed is set
  typedef struct packed {
    row_kind_t kind;
    logic [CFG_BITS-1:0] thr;
    logic [CFG_BITS-1:0] scale;
    slm_in_t  frame;
    logic     typed;
    logic     fires;
    slm_out_t lv;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  slm_in_t in_payload;
  logic out_valid;
  logic out_ready;
  slm_out_t out_payload;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  // Meter state as the predictor sees it
  logic [CFG_BITS-1:0]   thr_reg;
  logic [CFG_BITS-1:0]   scale_reg;
  logic [31:0]           acc_left;
  logic [31:0]           acc_right;
  logic [COUNT_BITS-1:0] frame_tally;

  slm_out_t levels_q[$];
  int levels_due;
  int errors;
  int quiet;
  bit gaps_on;

  plan_row_t plan [N_DIR] = '{
    // defaults after reset: no update yet
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'sd0, 1'b0}, 1'b1, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'sd0, 1'b1}, 1'b1, 1'b0, '0},
    // zero threshold: every end of buffer updates
    '{ROW_CFG_STRAY, 16'd0, 16'd1, '0, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'sd0, 1'b1}, 1'b1, 1'b1, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'h8000, 16'h8000, 1'b1}, 1'b1, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'h8000, 1'b1}, 1'b1, 1'b1,
      '{16'h0000, 16'hFFFF, 16'hFFFF}},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'h7FFF, 16'sd0, 1'b1}, 1'b1, 1'b1,
      '{16'hFFFF, 16'h0000, 16'hFFFF}},
    // zero scale acts as one
    '{ROW_CFG, 16'd0, 16'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd1, -16'sd1, 1'b1}, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'h5555, 16'hAAAA, 1'b1}, 1'b0, 1'b0, '0},
    // lowest nonzero threshold, largest scale
    '{ROW_CFG, 16'd1, 16'hFFFF, '0, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'h2AAA, 16'h5555, 1'b0}, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{-16'sd1, 16'sd1, 1'b1}, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd12345, -16'sd12345, 1'b1}, 1'b0, 1'b0, '0},
    // threshold not exceeded on the first end of buffer
    '{ROW_CFG, 16'd2, 16'd1, '0, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd100, -16'sd200, 1'b1}, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd300, -16'sd400, 1'b1}, 1'b0, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'sd0, 1'b1}, 1'b1, 1'b0, '0},
    '{ROW_FRAME, 16'd0, 16'd0, '{16'sd0, 16'sd0, 1'b1}, 1'b1, 1'b1, '0}
  };

  stereo_log_level_meter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // log10(num/den) in Q.52: normalize, divide to Q1.30, square out log2 bits
  function automatic logic [63:0] log10_fixed(input logic [63:0] num, input logic [63:0] den);
    int k;
    logic [63:0] dk, rem, mant, frac;
    k = 0;
    while (k < 62 && (num >> (k + 1)) >= den) k++;
    dk = den << k;
    rem = num - dk;
    mant = 64'd1;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem = rem << 1;
      mant = mant << 1;
      if (rem >= dk) begin
        rem = rem - dk;
        mant = mant | 64'd1;
      end
    end
    frac = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= 64'h8000_0000) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return ((64'(k) << FRAC_BITS) | frac) * 64'(LOG10_2_Q32);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] to_level(input logic [63:0] v);
    return (v > 64'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_BITS-1:0];
  endfunction

  function automatic logic [31:0] add_magnitude(input logic [31:0] acc,
                                                input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mag;
    logic [32:0] total;
    // Negate at sample width so the most negative sample maps to its magnitude
    mag = s;
    if (s[SAMPLE_BITS-1]) mag = ~s + 1'b1;
    total = {1'b0, acc} + 33'(mag);
    return total[32] ? '1 : total[31:0];
  endfunction

  // Advance the meter by one frame; returns 1 when the frame produces levels
  function automatic bit meter_frame(input slm_in_t f, output slm_out_t lv);
    logic [63:0] den, pl, pr;
    lv = '0;
    acc_left  = add_magnitude(acc_left, f.sample_left);
    acc_right = add_magnitude(acc_right, f.sample_right);
    if (frame_tally != COUNT_MAX) frame_tally = frame_tally + 1'b1;
    if (!f.end_of_buffer) return 1'b0;
    if (64'(frame_tally) * 2 <= 64'(thr_reg)) return 1'b0;
    den = 64'(frame_tally) * ((scale_reg == '0) ? 64'd1 : 64'(scale_reg));
    pl = log10_fixed(64'(acc_left) + den, den);
    pr = log10_fixed(64'(acc_right) + den, den);
    lv.level_left  = to_level((pl + (64'd1 << 35)) >> CH_SHIFT);
    lv.level_right = to_level((pr + (64'd1 << 35)) >> CH_SHIFT);
    lv.level_mono  = to_level((pl + pr + (64'd1 << 36)) >> MONO_SHIFT);
    acc_left = '0;
    acc_right = '0;
    frame_tally = '0;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] next_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 32) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one frame from a falling edge; return at the falling edge after transfer
  task automatic send_frame(input slm_in_t f, input logic typed, input logic fires,
                            input slm_out_t lv);
    slm_out_t got;
    bit fired;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= f;
    do @(posedge clk); while (!in_ready);
    fired = meter_frame(f, got);
    if (typed ? fires : fired) begin
      levels_q.push_back(typed ? lv : got);
      levels_due++;
    end
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_UPDATE_THRESHOLD: thr_reg = data;
      REG_LEVEL_SCALE:      scale_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Reprogram both registers once the meter has drained
  task automatic set_meter(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] scale,
                           input bit stray);
    in_valid <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    if (stray) cfg_write(REG_UNUSED, 16'($urandom));
    cfg_write(REG_UPDATE_THRESHOLD, thr);
    cfg_write(REG_LEVEL_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole buffers long enough to update, some short ones, some stray flags
  task automatic random_phase(input int frames_min, input int levels_min);
    int sent, len, half;
    slm_in_t f;
    sent = 0;
    while (sent < frames_min || levels_due < levels_min) begin
      half = thr_reg / 2;
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, half + 1);
      else len = half + $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        f.sample_left  = next_sample();
        f.sample_right = next_sample();
        f.end_of_buffer = (i == len - 1);
        if ($urandom_range(0, 9) == 0) f.end_of_buffer = ~f.end_of_buffer;
        send_frame(f, 1'b0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_level(input string name, input logic [LEVEL_BITS-1:0] want,
                             input logic [LEVEL_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each transferred result with the oldest pending prediction
  always @(posedge clk) begin : watch_levels
    slm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (levels_q.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, out_payload);
        errors++;
      end else begin
        want = levels_q.pop_front();
        check_level("level_left", want.level_left, out_payload.level_left);
        check_level("level_right", want.level_right, out_payload.level_right);
        check_level("level_mono", want.level_mono, out_payload.level_mono);
      end
    end
  end

  // Stall the result side in short random bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run after too long with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 0;
    errors = 0;
    levels_due = 0;
    gaps_on = 1'b1;
    thr_reg = THRESHOLD_RESET;
    scale_reg = SCALE_RESET;
    acc_left = '0;
    acc_right = '0;
    frame_tally = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    for (int i = 0; i < N_DIR; i++) begin
      case (plan[i].kind)
        ROW_CFG:       set_meter(plan[i].thr, plan[i].scale, 1'b0);
        ROW_CFG_STRAY: set_meter(plan[i].thr, plan[i].scale, 1'b1);
        default:       send_frame(plan[i].frame, plan[i].typed, plan[i].fires, plan[i].lv);
      endcase
    end

    set_meter(16'd1, 16'd1, 1'b0);
    random_phase(100, 0);
    set_meter(16'd6, 16'hFFFF, 1'b0);
    random_phase(100, 0);
    set_meter(16'($urandom_range(0, 30)), 16'($urandom), 1'b1);
    random_phase(100, 0);
    set_meter(16'd12, 16'($urandom_range(1, 500)), 1'b0);
    random_phase(100, 0);

    // Last part runs back to back with no stalls
    gaps_on = 1'b0;
    set_meter(16'($urandom_range(1, 20)), 16'($urandom_range(1, 3000)), 1'b0);
    random_phase(100, 48);
    in_valid <= 1'b0;

    // Drain, then give the meter time to show any stray result
    while (levels_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
